### src/tsd_pkg.sv
package tsd_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int POS_BITS     = 5;
  localparam int TOL_BITS     = 31;
  localparam int CMD_BITS     = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int DEF_MAX_A    = 32;
  localparam int DEF_MAX_B    = 32;

  localparam logic [CMD_BITS-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_RUN    = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE_NEG = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_SIDED     = 2'd2;

  typedef struct packed {
    logic [CMD_BITS-1:0]          command;
    logic signed [VALUE_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] out_value;
    logic [POS_BITS-1:0]          a_position;
    logic                         last;
    logic                         empty_res;
    logic                         overflow;
  } out_t;

  typedef struct packed {
    logic busy;
    logic run_done;
  } ctrl_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_MATCH,
    ST_GROUP,
    ST_FINISH
  } state_t;

endpackage

### src/tsd_mem.sv
module tsd_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/tsd_ctrl.sv
module tsd_ctrl #(
  parameter int AW    = 5,
  parameter int BW    = 5,
  parameter int ACW   = 6,
  parameter int BCW   = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                run,
  input  logic [ACW-1:0]                      a_count,
  input  logic [BCW-1:0]                      b_count,
  input  logic [tsd_pkg::TOL_BITS-1:0]        tolerance,
  input  logic                                tolerance_negative,
  input  logic                                one_sided,
  input  logic                                dropped,
  output logic [AW-1:0]                       a_raddr,
  input  logic [tsd_pkg::VALUE_BITS-1:0]      a_rdata,
  output logic [BW-1:0]                       b_raddr,
  input  logic [tsd_pkg::VALUE_BITS-1:0]      b_rdata,
  output tsd_pkg::ctrl_stat_t                 stat,
  output logic                                result_valid,
  output tsd_pkg::out_t                       result
);

  localparam int SW = (ACW > BCW) ? ACW : BCW;
  localparam int VB = tsd_pkg::VALUE_BITS;

  tsd_pkg::state_t state, state_next;

  logic [SW-1:0]        issue;
  logic [SW-1:0]        rd_idx;
  logic                 rd_vld;
  logic [SW-1:0]        lim;
  logic                 scan_done;

  logic                 best_found;
  logic signed [VB-1:0] best_val;
  logic [AW-1:0]        best_idx;
  logic                 have_prev;
  logic signed [VB-1:0] prev_val;
  logic [AW-1:0]        prev_idx;
  logic signed [VB-1:0] cur_val;
  logic [AW-1:0]        cur_idx;
  logic                 matched;
  logic                 prev_unm;
  logic                 pend_valid;
  logic signed [VB-1:0] pend_val;
  logic [AW-1:0]        pend_idx;

  logic signed [VB-1:0] a_v;
  logic [AW-1:0]        a_i;
  logic                 gt_prev;
  logic                 lt_best;
  logic                 b_hit;
  logic                 grp_near;

  // |a - b| <= tolerance on a 33-bit difference
  function automatic logic near_value(input logic signed [VB-1:0] a,
                                      input logic signed [VB-1:0] b,
                                      input logic [tsd_pkg::TOL_BITS-1:0] tol);
    logic signed [VB:0] d;
    logic [VB:0]        mag;
    d   = {a[VB-1], a} - {b[VB-1], b};
    mag = d[VB] ? (~d + 1'b1) : d;
    return mag <= (VB+1)'(tol);
  endfunction

  assign lim       = (state == tsd_pkg::ST_FIND) ? SW'(a_count) : SW'(b_count);
  assign scan_done = (issue == lim) && !rd_vld;
  assign a_raddr   = AW'(issue);
  assign b_raddr   = BW'(issue);

  assign a_v = a_rdata;
  assign a_i = AW'(rd_idx);
  // (value, load position) ordering gives the stable sort order
  assign gt_prev = !have_prev || (a_v > prev_val) || ((a_v == prev_val) && (a_i > prev_idx));
  assign lt_best = !best_found || (a_v < best_val) || ((a_v == best_val) && (a_i < best_idx));

  assign b_hit = near_value(cur_val, b_rdata, tolerance) &&
                 (!one_sided || (tolerance_negative ? (cur_val < $signed(b_rdata))
                                                    : (cur_val > $signed(b_rdata))));
  assign grp_near = near_value(cur_val, prev_val, tolerance);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    stat.busy     = (state != tsd_pkg::ST_IDLE);
    stat.run_done = 1'b0;
    case (state)
      tsd_pkg::ST_IDLE: begin
        if (run) state_next = tsd_pkg::ST_FIND;
      end
      tsd_pkg::ST_FIND: begin
        if (scan_done) state_next = best_found ? tsd_pkg::ST_MATCH : tsd_pkg::ST_FINISH;
      end
      tsd_pkg::ST_MATCH: begin
        if (scan_done) state_next = tsd_pkg::ST_GROUP;
      end
      tsd_pkg::ST_GROUP: begin
        state_next = tsd_pkg::ST_FIND;
      end
      tsd_pkg::ST_FINISH: begin
        stat.run_done = 1'b1;
        state_next    = tsd_pkg::ST_IDLE;
      end
      default: begin
        state_next = tsd_pkg::ST_IDLE;
      end
    endcase
  end

  // memory scan: one read issued per cycle, data in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      issue  <= '0;
    end else if ((state == tsd_pkg::ST_FIND || state == tsd_pkg::ST_MATCH) && !scan_done) begin
      if (issue < lim) begin
        rd_vld <= 1'b1;
        rd_idx <= issue;
        issue  <= issue + 1'b1;
      end else begin
        rd_vld <= 1'b0;
      end
    end else begin
      rd_vld <= 1'b0;
      issue  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found   <= 1'b0;
      have_prev    <= 1'b0;
      prev_unm     <= 1'b0;
      pend_valid   <= 1'b0;
      matched      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        tsd_pkg::ST_IDLE: begin
          have_prev  <= 1'b0;
          prev_unm   <= 1'b0;
          pend_valid <= 1'b0;
          best_found <= 1'b0;
        end
        tsd_pkg::ST_FIND: begin
          if (rd_vld && gt_prev && lt_best) begin
            best_found <= 1'b1;
            best_val   <= a_v;
            best_idx   <= a_i;
          end
          if (scan_done) begin
            cur_val <= best_val;
            cur_idx <= best_idx;
            matched <= 1'b0;
          end
        end
        tsd_pkg::ST_MATCH: begin
          if (rd_vld && b_hit) matched <= 1'b1;
        end
        tsd_pkg::ST_GROUP: begin
          if (matched) begin
            prev_unm <= 1'b0;
          end else begin
            prev_unm <= 1'b1;
            if (prev_unm && grp_near) begin
              pend_idx <= cur_idx;
            end else begin
              if (pend_valid) begin
                result_valid      <= 1'b1;
                result.out_value  <= pend_val;
                result.a_position <= tsd_pkg::POS_BITS'(pend_idx);
                result.last       <= 1'b0;
                result.empty_res  <= 1'b0;
                result.overflow   <= dropped;
              end
              pend_valid <= 1'b1;
              pend_val   <= cur_val;
              pend_idx   <= cur_idx;
            end
          end
          have_prev  <= 1'b1;
          prev_val   <= cur_val;
          prev_idx   <= cur_idx;
          best_found <= 1'b0;
        end
        tsd_pkg::ST_FINISH: begin
          result_valid     <= 1'b1;
          result.last      <= 1'b1;
          result.overflow  <= dropped;
          result.empty_res <= !pend_valid;
          if (pend_valid) begin
            result.out_value  <= pend_val;
            result.a_position <= tsd_pkg::POS_BITS'(pend_idx);
          end else begin
            result.out_value  <= '0;
            result.a_position <= '0;
          end
        end
        default: begin
          best_found <= 1'b0;
        end
      endcase
    end
  end

endmodule

### src/tolerant_set_difference.sv
// channel  | ports                          | transaction
// item     | start, busy, item              | start high, busy low at the clock edge
// result   | result_valid, result           | one cycle per result, strobe marks it
// config   | cfg_write, cfg_index, cfg_data | write at each edge with cfg_write high
//
// loads can follow back to back
// a run with both stores loaded goes through the sorted a values in order: per value a
// pass over the a memory finds it, a pass over the b memory tests it and a group step
// handles it; then a last a pass finds nothing and a finish step ends the run; an
// empty a store takes one a pass and the finish step
// sync reset clears counts, overflow flag, config and control; memories are not cleared
// results cannot be stalled; busy drops in the cycle the last result of a run is out
module tolerant_set_difference #(
  parameter int MAX_A = tsd_pkg::DEF_MAX_A,
  parameter int MAX_B = tsd_pkg::DEF_MAX_B
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  tsd_pkg::in_t                      item,
  output logic                              result_valid,
  output tsd_pkg::out_t                     result,
  input  logic                              cfg_write,
  input  logic [tsd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tsd_pkg::TOL_BITS-1:0]      cfg_data
);

  localparam int AW  = (MAX_A > 1) ? $clog2(MAX_A) : 1;
  localparam int BW  = (MAX_B > 1) ? $clog2(MAX_B) : 1;
  localparam int ACW = $clog2(MAX_A + 1);
  localparam int BCW = $clog2(MAX_B + 1);
  localparam int VB  = tsd_pkg::VALUE_BITS;

  logic [tsd_pkg::TOL_BITS-1:0] tolerance;
  logic                         tolerance_negative;
  logic                         one_sided;
  logic [ACW-1:0]               a_count;
  logic [BCW-1:0]               b_count;
  logic                         dropped;

  logic                         accept;
  logic                         a_we;
  logic                         b_we;
  logic [AW-1:0]                a_raddr;
  logic [BW-1:0]                b_raddr;
  logic [VB-1:0]                a_rdata;
  logic [VB-1:0]                b_rdata;
  tsd_pkg::ctrl_stat_t          stat;

  assign busy   = stat.busy;
  assign accept = start && !stat.busy;
  assign a_we   = accept && (item.command == tsd_pkg::CMD_LOAD_A) && (a_count < ACW'(MAX_A));
  assign b_we   = accept && (item.command == tsd_pkg::CMD_LOAD_B) && (b_count < BCW'(MAX_B));

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance          <= '0;
      tolerance_negative <= 1'b0;
      one_sided          <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        tsd_pkg::CFG_TOLERANCE:     tolerance          <= cfg_data;
        tsd_pkg::CFG_TOLERANCE_NEG: tolerance_negative <= cfg_data[0];
        tsd_pkg::CFG_ONE_SIDED:     one_sided          <= cfg_data[0];
        default: begin
          tolerance <= tolerance;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_count <= '0;
      b_count <= '0;
      dropped <= 1'b0;
    end else if (stat.run_done) begin
      a_count <= '0;
      b_count <= '0;
      dropped <= 1'b0;
    end else begin
      if (a_we) a_count <= a_count + 1'b1;
      if (b_we) b_count <= b_count + 1'b1;
      // full store drops the load
      if (accept && !a_we && !b_we &&
          (item.command == tsd_pkg::CMD_LOAD_A || item.command == tsd_pkg::CMD_LOAD_B)) begin
        dropped <= 1'b1;
      end
    end
  end

  tsd_mem #(.WIDTH(VB), .DEPTH(MAX_A), .AW(AW)) u_a_mem (
    .clk   (clk),
    .we    (a_we),
    .waddr (AW'(a_count)),
    .wdata (item.value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  tsd_mem #(.WIDTH(VB), .DEPTH(MAX_B), .AW(BW)) u_b_mem (
    .clk   (clk),
    .we    (b_we),
    .waddr (BW'(b_count)),
    .wdata (item.value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  tsd_ctrl #(
    .AW    (AW),
    .BW    (BW),
    .ACW   (ACW),
    .BCW   (BCW)
  ) u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .run                (accept && (item.command == tsd_pkg::CMD_RUN)),
    .a_count            (a_count),
    .b_count            (b_count),
    .tolerance          (tolerance),
    .tolerance_negative (tolerance_negative),
    .one_sided          (one_sided),
    .dropped            (dropped),
    .a_raddr            (a_raddr),
    .a_rdata            (a_rdata),
    .b_raddr            (b_raddr),
    .b_rdata            (b_rdata),
    .stat               (stat),
    .result_valid       (result_valid),
    .result             (result)
  );

endmodule

### bench/tb.sv
module tb;

  localparam int CYCLE_LIMIT = 3000000;
  // command code that the block ignores
  localparam logic [tsd_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  class diff_scoreboard;
    longint        a_vals[$];
    int unsigned   a_pos[$];
    longint        b_vals[$];
    bit            dropped;
    longint        tol;
    bit            tol_neg;
    bit            one_side;
    tsd_pkg::out_t pending_q[$];
    int            errors;
    int            results_seen;
    int            runs;
    int            overflow_runs;
    int            empty_runs;

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function bit near_value(longint a, longint b);
      longint d;
      d = (a >= b) ? a - b : b - a;
      return d <= tol;
    endfunction

    function bit is_matched(longint a);
      foreach (b_vals[j]) begin
        if (!near_value(a, b_vals[j])) continue;
        if (!one_side) return 1;
        if (tol_neg ? (a < b_vals[j]) : (a > b_vals[j])) return 1;
      end
      return 0;
    endfunction

    function void predict_run();
      longint        v;
      int unsigned   p;
      int            j;
      int            n;
      bit            prev_unmatched;
      tsd_pkg::out_t r;
      tsd_pkg::out_t found[$];
      // stable insertion sort keeps load order among equal values
      for (int i = 1; i < a_vals.size(); i++) begin
        v = a_vals[i];
        p = a_pos[i];
        j = i;
        while (j > 0 && a_vals[j-1] > v) begin
          a_vals[j] = a_vals[j-1];
          a_pos[j] = a_pos[j-1];
          j--;
        end
        a_vals[j] = v;
        a_pos[j] = p;
      end
      prev_unmatched = 0;
      for (int i = 0; i < a_vals.size(); i++) begin
        if (is_matched(a_vals[i])) begin
          prev_unmatched = 0;
          continue;
        end
        n = found.size();
        if (n > 0 && prev_unmatched && near_value(a_vals[i], a_vals[i-1])) begin
          found[n-1].a_position = a_pos[i][4:0];
        end else begin
          r = '0;
          r.out_value = a_vals[i][31:0];
          r.a_position = a_pos[i][4:0];
          r.overflow = dropped;
          found.push_back(r);
        end
        prev_unmatched = 1;
      end
      if (found.size() == 0) begin
        r = '0;
        r.last = 1;
        r.empty_res = 1;
        r.overflow = dropped;
        found.push_back(r);
        empty_runs++;
      end else begin
        found[found.size()-1].last = 1;
      end
      if (dropped) overflow_runs++;
      foreach (found[k]) pending_q.push_back(found[k]);
      a_vals.delete();
      a_pos.delete();
      b_vals.delete();
      dropped = 0;
      runs++;
    endfunction

    function void note_item(tsd_pkg::in_t it);
      longint v;
      v = longint'($signed(it.value));
      case (it.command)
        tsd_pkg::CMD_LOAD_A: begin
          if (a_vals.size() < tsd_pkg::DEF_MAX_A) begin
            a_pos.push_back(a_vals.size());
            a_vals.push_back(v);
          end else dropped = 1;
        end
        tsd_pkg::CMD_LOAD_B: begin
          if (b_vals.size() < tsd_pkg::DEF_MAX_B) b_vals.push_back(v);
          else dropped = 1;
        end
        tsd_pkg::CMD_RUN: predict_run();
        default: ;
      endcase
    endfunction

    function void check_result(tsd_pkg::out_t got);
      tsd_pkg::out_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        flag($sformatf("unexpected result %p", got));
        return;
      end
      want = pending_q.pop_front();
      if (got.out_value !== want.out_value || got.a_position !== want.a_position ||
          got.last !== want.last || got.empty_res !== want.empty_res ||
          got.overflow !== want.overflow)
        flag($sformatf("expected %p, got %p", want, got));
    endfunction
  endclass

  logic          clk = 0;
  logic          rst;
  logic          start;
  logic          busy;
  tsd_pkg::in_t  item;
  logic          result_valid;
  tsd_pkg::out_t result;
  logic          cfg_write;
  logic [tsd_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [tsd_pkg::TOL_BITS-1:0]     cfg_data;

  diff_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 0;
  int sent = 0;

  tolerant_set_difference u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid) sb.check_result(result);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send(logic [tsd_pkg::CMD_BITS-1:0] cmd,
                      logic [tsd_pkg::VALUE_BITS-1:0] val);
    tsd_pkg::in_t t;
    t.command = cmd;
    t.value = val;
    item <= t;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_item(item);
    if (cmd != CMD_UNUSED) sent++;
    // each following cycle idles with the given chance
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
  endtask

  // hold off until every expected transaction is out and the block is idle
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending_q.size() > 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [tsd_pkg::TOL_BITS-1:0] tol, bit neg, bit one);
    cfg_write <= 1;
    cfg_index <= tsd_pkg::CFG_TOLERANCE;
    cfg_data <= tol;
    @(posedge clk);
    cfg_index <= tsd_pkg::CFG_TOLERANCE_NEG;
    cfg_data <= {{(tsd_pkg::TOL_BITS-1){1'b0}}, neg};
    @(posedge clk);
    cfg_index <= tsd_pkg::CFG_ONE_SIDED;
    cfg_data <= {{(tsd_pkg::TOL_BITS-1){1'b0}}, one};
    @(posedge clk);
    cfg_write <= 0;
    sb.tol = longint'(tol);
    sb.tol_neg = neg;
    sb.one_side = one;
  endtask

  function automatic logic [tsd_pkg::VALUE_BITS-1:0] pick_value();
    int sel;
    int base;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      // clustered values so tolerance and grouping decide the outcome
      base = $urandom_range(0, 6) - 3;
      return (base <<< 16) + ($urandom_range(0, 15) <<< 13) - 32'sd65536;
    end
    if (sel < 85) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [tsd_pkg::TOL_BITS-1:0] pick_tol();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'h7fff_ffff;
      2: return 31'd16384;
      3: return 31'd65536;
      4: return 31'd196608;
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic random_set();
    int na;
    int nb;
    na = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
    nb = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 8);
    while (na + nb > 0) begin
      if ($urandom_range(0, 24) == 0) send(CMD_UNUSED, $urandom);
      if (na > 0 && (nb == 0 || $urandom_range(0, 1))) begin
        send(tsd_pkg::CMD_LOAD_A, pick_value());
        na--;
      end else begin
        send(tsd_pkg::CMD_LOAD_B, pick_value());
        nb--;
      end
    end
    // end every set with a run
    send(tsd_pkg::CMD_RUN, $urandom);
  endtask

  initial begin
    rst = 1;
    start = 0;
    item = '0;
    cfg_write = 0;
    cfg_index = tsd_pkg::CFG_TOLERANCE;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, duplicates, empty run, ignored command
    configure('0, 0, 0);
    send(tsd_pkg::CMD_RUN, 32'h0);
    send(tsd_pkg::CMD_LOAD_A, 32'h7fff_ffff);
    send(tsd_pkg::CMD_LOAD_A, 32'h8000_0000);
    send(tsd_pkg::CMD_LOAD_A, 32'h0);
    send(tsd_pkg::CMD_LOAD_A, 32'h0);
    send(CMD_UNUSED, 32'hffff_ffff);
    send(tsd_pkg::CMD_LOAD_B, 32'h8000_0000);
    send(tsd_pkg::CMD_RUN, 32'hffff_ffff);
    drain();
    configure(31'd65536, 1, 1);
    send(tsd_pkg::CMD_LOAD_A, 32'h0001_0000);
    send(tsd_pkg::CMD_LOAD_A, 32'h0001_8000);
    send(tsd_pkg::CMD_LOAD_A, 32'h0002_0000);
    send(tsd_pkg::CMD_LOAD_A, 32'h0000_8000);
    send(tsd_pkg::CMD_LOAD_B, 32'h0001_4000);
    send(tsd_pkg::CMD_RUN, 32'h0);
    drain();
    configure(31'h7fff_ffff, 0, 0);
    send(tsd_pkg::CMD_LOAD_A, 32'h8000_0000);
    send(tsd_pkg::CMD_LOAD_A, 32'h7fff_ffff);
    send(tsd_pkg::CMD_LOAD_B, 32'h0);
    send(tsd_pkg::CMD_RUN, 32'h0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 38 : (phase == 1) ? 64 : 0;
      for (int grp = 0; grp < 4; grp++) begin
        drain();
        configure(pick_tol(), $urandom_range(0, 1), $urandom_range(0, 1));
        while (sent < 22 + (phase * 4 + grp + 1) * 30) random_set();
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (sb.pending_q.size() > 0)
      sb.flag($sformatf("%0d results never arrived", sb.pending_q.size()));
    $display("%0d transactions sent, %0d runs, %0d results checked", sent, sb.runs,
             sb.results_seen);
    $display("%0d runs with nothing left, %0d runs with dropped loads", sb.empty_runs,
             sb.overflow_runs);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### tolerant_set_difference.f
src/tsd_pkg.sv
src/tsd_mem.sv
src/tsd_ctrl.sv
src/tolerant_set_difference.sv
bench/tb.sv
